[hdl/two_dim_first_fit_bin_packer_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the two-dimensional first-fit bin packer
// Shared helpers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef TWO_DIM_FIRST_FIT_BIN_PACKER_UNIT_DEFINES_SVH
`define TWO_DIM_FIRST_FIT_BIN_PACKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define BPACK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define BPACK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bpack_pkg.sv]
// ----------------------------------------------------------------------------
// bpack_pkg
// Types and constants shared by the bin packer modules.
// ----------------------------------------------------------------------------
package bpack_pkg;

    // Width of size, weight and limit values.
    localparam int VAL_W = 24;

    // Reset value of both limit registers.
    localparam logic [VAL_W-1:0] LIMIT_RESET = 24'd1000;

    // Stream widths.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;

    // Input item layout.
    localparam int IN_FRESH_BIT  = 0;
    localparam int IN_SIZE_LSB   = 1;
    localparam int IN_WEIGHT_LSB = 25;

    // Result item layout.
    localparam int OUT_BIN_LSB  = 0;
    localparam int OUT_BIN_W    = 8;
    localparam int OUT_OPEN_BIT = 8;
    localparam int OUT_OVER_BIT = 9;
    localparam int OUT_FULL_BIT = 10;
    localparam int OUT_USED_LSB = 11;
    localparam int OUT_USED_W   = 9;
    localparam int OUT_PAD_LSB  = 20;

    // Register interface.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_SIZE_LIMIT   = 1'b0;
    localparam logic REG_WEIGHT_LIMIT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch a new item, apply start_fresh
        logic scan;    // read and test one bin per cycle
        logic commit;  // update the bin, the count and the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;       // the bin under test takes the item
        logic scan_end;  // every open bin was tested without a fit
        logic out_free;  // result register can take a new result
    } t_status;

endpackage

[hdl/bpack_regs.sv]
// ----------------------------------------------------------------------------
// bpack_regs
// Limit registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module bpack_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bpack_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bpack_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bpack_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready,
    output logic [bpack_pkg::VAL_W-1:0]          o_size_limit,
    output logic [bpack_pkg::VAL_W-1:0]          o_weight_limit
);
    import bpack_pkg::*;

    logic [VAL_W-1:0] r_size_limit;
    logic [VAL_W-1:0] r_weight_limit;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_limit   <= LIMIT_RESET;
            r_weight_limit <= LIMIT_RESET;
        end else if (wr_en) begin
            if (reg_sel == REG_SIZE_LIMIT) begin
                r_size_limit <= pwdata[VAL_W-1:0];
            end else begin
                r_weight_limit <= pwdata[VAL_W-1:0];
            end
        end
    end

    // Read data is the selected register, zero extended.
    always_comb begin
        if (reg_sel == REG_SIZE_LIMIT) begin
            prdata = APB_DATA_W'(r_size_limit);
        end else begin
            prdata = APB_DATA_W'(r_weight_limit);
        end
    end

    assign o_size_limit   = r_size_limit;
    assign o_weight_limit = r_weight_limit;

endmodule

[hdl/bpack_ctrl.sv]
// ----------------------------------------------------------------------------
// bpack_ctrl
// Controller that sequences accept, bin scan and commit for each item.
// ----------------------------------------------------------------------------
module bpack_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    input  bpack_pkg::t_status i_status,
    output bpack_pkg::t_cmd    o_cmd
);
    import bpack_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.hit || i_status.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/bpack_dpath.sv]
// ----------------------------------------------------------------------------
// bpack_dpath
// Bin total memory, fit test, open bin count and result register.
// ----------------------------------------------------------------------------
module bpack_dpath #(
    parameter int MAX_BINS = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bpack_pkg::t_cmd                      i_cmd,
    output bpack_pkg::t_status                   o_status,
    input  logic [bpack_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic [bpack_pkg::VAL_W-1:0]          i_size_limit,
    input  logic [bpack_pkg::VAL_W-1:0]          i_weight_limit,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [bpack_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import bpack_pkg::*;

    localparam int IW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BINS);

    // Each entry holds the weight total above the size total.
    logic [2*VAL_W-1:0] r_mem [MAX_BINS];
    logic [2*VAL_W-1:0] r_rd_data;

    logic [VAL_W-1:0]   r_item_size;
    logic [VAL_W-1:0]   r_item_weight;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_issue_idx;
    logic [IW-1:0]      r_cmp_idx;
    logic               r_cmp_vld;
    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic [VAL_W-1:0]   r_sum_size;
    logic [VAL_W-1:0]   r_sum_weight;

    logic               r_out_vld;
    logic [OUT_BIN_W-1:0]  r_out_bin;
    logic               r_out_open;
    logic               r_out_over;
    logic               r_out_full;
    logic [OUT_USED_W-1:0] r_out_used;

    logic               issue_now;
    logic [VAL_W:0]     sum_size;
    logic [VAL_W:0]     sum_weight;
    logic               fit;
    logic               hit;
    logic               room;
    logic               over;
    logic [IW-1:0]      n_bin;
    logic [CW-1:0]      n_used;
    logic               n_open;
    logic               n_over;
    logic               n_full;
    logic [31:0]        bin_ext;
    logic [31:0]        used_ext;

    // Fit test of the bin whose totals were read last cycle.
    assign issue_now  = r_issue_idx < r_count;
    assign sum_size   = {1'b0, r_rd_data[VAL_W-1:0]} + {1'b0, r_item_size};
    assign sum_weight = {1'b0, r_rd_data[2*VAL_W-1:VAL_W]} + {1'b0, r_item_weight};
    assign fit        = (sum_size <= {1'b0, i_size_limit}) &&
                        (sum_weight <= {1'b0, i_weight_limit});
    assign hit        = r_cmp_vld && fit;
    assign room       = r_count < MAX_CNT;
    assign over       = (r_item_size > i_size_limit) || (r_item_weight > i_weight_limit);

    assign o_status.hit      = i_cmd.scan && hit;
    assign o_status.scan_end = !r_cmp_vld && !issue_now;
    assign o_status.out_free = !r_out_vld || i_m_tready;

    // Item registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item_size   <= i_s_tdata[IN_SIZE_LSB +: VAL_W];
            r_item_weight <= i_s_tdata[IN_WEIGHT_LSB +: VAL_W];
        end
    end

    // Scan pointer and compare stage, one bin per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_idx <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
        end else if (i_cmd.load) begin
            r_issue_idx <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
        end else if (i_cmd.scan) begin
            if (hit) begin
                r_hit     <= 1'b1;
                r_cmp_vld <= 1'b0;
            end else begin
                r_cmp_vld <= issue_now;
                if (issue_now) begin
                    r_issue_idx <= r_issue_idx + CW'(1);
                end
            end
        end
    end

    // Compare index and the sums of a fitting bin.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_cmp_idx <= r_issue_idx[IW-1:0];
            if (hit) begin
                r_hit_idx    <= r_cmp_idx;
                r_sum_size   <= sum_size[VAL_W-1:0];
                r_sum_weight <= sum_weight[VAL_W-1:0];
            end
        end
    end

    // Bin total memory: one read and one write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && issue_now) begin
            r_rd_data <= r_mem[r_issue_idx[IW-1:0]];
        end
        if (i_cmd.commit) begin
            if (r_hit) begin
                r_mem[r_hit_idx] <= {r_sum_weight, r_sum_size};
            end else if (room) begin
                r_mem[r_count[IW-1:0]] <= {r_item_weight, r_item_size};
            end
        end
    end

    // Open bin count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load && i_s_tdata[IN_FRESH_BIT]) begin
            r_count <= '0;
        end else if (i_cmd.commit && !r_hit && room) begin
            r_count <= r_count + CW'(1);
        end
    end

    // Result of the current item.
    always_comb begin
        if (r_hit) begin
            n_bin  = r_hit_idx;
            n_used = r_count;
            n_open = 1'b0;
            n_over = 1'b0;
            n_full = 1'b0;
        end else if (room) begin
            n_bin  = r_count[IW-1:0];
            n_used = r_count + CW'(1);
            n_open = 1'b1;
            n_over = over;
            n_full = 1'b0;
        end else begin
            n_bin  = '0;
            n_used = r_count;
            n_open = 1'b0;
            n_over = 1'b0;
            n_full = 1'b1;
        end
    end

    assign bin_ext  = 32'(n_bin);
    assign used_ext = 32'(n_used);

    // Output register, freed when the receiver takes the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_bin  <= bin_ext[OUT_BIN_W-1:0];
            r_out_open <= n_open;
            r_out_over <= n_over;
            r_out_full <= n_full;
            r_out_used <= used_ext[OUT_USED_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'b0000, r_out_used, r_out_full, r_out_over, r_out_open, r_out_bin};

endmodule

[hdl/two_dim_first_fit_bin_packer_unit.sv]
// ----------------------------------------------------------------------------
// two_dim_first_fit_bin_packer_unit
// Two-dimensional first-fit bin packer with size and weight limits.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis stream: start_fresh, size and weight. Each item
// is placed in the lowest open bin whose size and weight totals stay within
// the limits; otherwise a new bin is opened (flagged as oversize when the
// item alone breaks a limit), or the item is dropped once MAX_BINS bins are
// open. One result per item leaves on the m_axis stream.
// Limits must be written over the APB port only while the block is idle;
// the user is bound to this, as the block does not enforce it. One item is
// in work at a time: it is taken in idle, then the open bins are read from
// the bin total memory in order, one per cycle, and each is tested against
// the item after its read, until one fits or all are tested; the result is
// then committed to the output register. The scan time grows with the index
// of the fitting bin, or with the number of open bins when none fits.
// A result waits in the output register while the receiver stalls; a new item
// is still taken, and its result is held back until the register frees.
// Reset clears the open bin count, the handshakes and sets both limits to
// 1000; the bin totals need no clearing.
// ----------------------------------------------------------------------------
module two_dim_first_fit_bin_packer_unit #(
    parameter int MAX_BINS = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input item: [0] start_fresh, [24:1] item_size, [48:25] item_weight.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [bpack_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Result: [7:0] bin_index, [8] opened_new, [9] oversize, [10] bins_full,
    // [19:11] bins_in_use.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [bpack_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Register port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bpack_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bpack_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bpack_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import bpack_pkg::*;

    t_cmd             cmd;
    t_status          status;
    logic [VAL_W-1:0] size_limit;
    logic [VAL_W-1:0] weight_limit;

    // Limit registers.
    bpack_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_size_limit   (size_limit),
        .o_weight_limit (weight_limit)
    );

    // Sequencer.
    bpack_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    // Bin storage and result path.
    bpack_dpath #(
        .MAX_BINS (MAX_BINS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_s_tdata      (s_axis_tdata),
        .i_size_limit   (size_limit),
        .i_weight_limit (weight_limit),
        .o_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .o_m_tdata      (m_axis_tdata)
    );

endmodule

[hdl/bpack_checker.sv]
// ----------------------------------------------------------------------------
// bpack_checker
// Port-level checks on the result stream of the bin packer.
// ----------------------------------------------------------------------------
`include "two_dim_first_fit_bin_packer_unit_defines.svh"

module bpack_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [bpack_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import bpack_pkg::*;

    logic                  opened;
    logic                  over;
    logic                  full;
    logic [OUT_BIN_W-1:0]  bin;
    logic [OUT_USED_W-1:0] used;

    assign opened = m_axis_tdata[OUT_OPEN_BIT];
    assign over   = m_axis_tdata[OUT_OVER_BIT];
    assign full   = m_axis_tdata[OUT_FULL_BIT];
    assign bin    = m_axis_tdata[OUT_BIN_LSB +: OUT_BIN_W];
    assign used   = m_axis_tdata[OUT_USED_LSB +: OUT_USED_W];

    // A stalled result keeps its valid and its data.
    `BPACK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // A dropped item reports bin zero and no new bin.
    `BPACK_ASSERT_NOW(a_full_clean, i_clk, i_rst_n, m_axis_tvalid && full,
        bin == '0 && !opened && !over, "dropped item carries placement flags")

    // Oversize is only reported for an item that opened a bin.
    `BPACK_ASSERT_NOW(a_over_open, i_clk, i_rst_n, m_axis_tvalid && over,
        opened, "oversize without a new bin")

    // Opening a bin leaves at least one bin in use.
    `BPACK_ASSERT_NOW(a_open_used, i_clk, i_rst_n, m_axis_tvalid && opened,
        used != '0, "new bin but no bin in use")

endmodule

bind two_dim_first_fit_bin_packer_unit bpack_checker u_bpack_checker (.*);

[bench/two_dim_first_fit_bin_packer_unit_test.sv]
// ----------------------------------------------------------------------------
// Testbench for the two-dimensional first-fit bin packer
// Drives items on the input stream and checks every result against its typed
// table entry or a first-fit placement predictor with its own bin totals and limits.
// A short table of directed items comes first. Random phases follow, each
// with its own size and weight limits: the reset limits, zero limits that
// fill every bin, full-scale limits, mixed and random limits. Both stream
// sides idle and stall at random, and the limits are written and read back
// over the register port only while no result is outstanding.
// ----------------------------------------------------------------------------
module two_dim_first_fit_bin_packer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpack_pkg::*;

    localparam int BIN_COUNT  = 256;
    localparam int PHASES     = 6;
    localparam int FILL_PHASE = 1;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    // One placement result, as predicted or as typed in the table.
    typedef struct packed {
        logic [7:0] bin_index;
        logic       opened_new;
        logic       oversize;
        logic       bins_full;
        logic [8:0] bins_in_use;
    } t_placement;

    // An expectation that is either typed in or left to the predictor.
    typedef struct packed {
        logic       typed;
        t_placement want;
    } t_golden;

    // One row of the directed table.
    typedef struct packed {
        logic             fresh;
        logic [VAL_W-1:0] item_size;
        logic [VAL_W-1:0] item_weight;
        t_golden          gold;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Predictor state: bin totals, open bin count and the limits.
    logic [VAL_W-1:0] size_total   [BIN_COUNT];
    logic [VAL_W-1:0] weight_total [BIN_COUNT];
    logic [8:0]       bins_open;
    logic [VAL_W-1:0] size_cap;
    logic [VAL_W-1:0] weight_cap;

    t_placement placement_q [$];
    t_golden    golden_q [$];
    t_row       rows [$];

    int  n_sent;
    int  n_results;
    int  errors;
    bit  no_idle;

    t_placement predicted;
    t_placement wanted;
    t_golden    gold_head;

    two_dim_first_fit_bin_packer_unit #(
        .MAX_BINS(BIN_COUNT)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // First-fit placement of one item; updates the predictor state.
    function automatic t_placement first_fit_place(input logic fresh,
                                                   input logic [VAL_W-1:0] item_size,
                                                   input logic [VAL_W-1:0] item_weight);
        t_placement   res;
        logic [VAL_W:0] sum_size;
        logic [VAL_W:0] sum_weight;
        bit           found;
        int           idx;
        res = '0;
        found = 1'b0;
        if (fresh) begin
            bins_open = '0;
        end
        for (idx = 0; idx < int'(bins_open) && !found; idx++) begin
            sum_size   = {1'b0, size_total[idx]} + {1'b0, item_size};
            sum_weight = {1'b0, weight_total[idx]} + {1'b0, item_weight};
            if (sum_size <= {1'b0, size_cap} && sum_weight <= {1'b0, weight_cap}) begin
                size_total[idx]   = sum_size[VAL_W-1:0];
                weight_total[idx] = sum_weight[VAL_W-1:0];
                res.bin_index     = idx[7:0];
                res.bins_in_use   = bins_open;
                found = 1'b1;
            end
        end
        if (!found) begin
            if (int'(bins_open) < BIN_COUNT) begin
                idx = int'(bins_open);
                size_total[idx]   = item_size;
                weight_total[idx] = item_weight;
                bins_open         = bins_open + 9'd1;
                res.bin_index     = idx[7:0];
                res.opened_new    = 1'b1;
                res.oversize      = (item_size > size_cap) || (item_weight > weight_cap);
                res.bins_in_use   = bins_open;
            end else begin
                res.bins_full   = 1'b1;
                res.bins_in_use = bins_open;
            end
        end
        return res;
    endfunction

    // Draws a field value that is mostly well placed against a limit.
    function automatic logic [VAL_W-1:0] pick_value(input logic [VAL_W-1:0] cap);
        int unsigned roll;
        int unsigned val;
        int unsigned below;
        int unsigned limit;
        limit = 32'(cap);
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            val = $urandom_range(0, limit / 3 + 1);
        end else if (roll < 85) begin
            below = (limit < 8) ? limit : 8;
            val = limit - $urandom_range(0, below);
            if ($urandom_range(0, 3) == 0 && val < 32'(VAL_MAX)) begin
                val = val + 1;
            end
        end else begin
            val = $urandom & 32'(VAL_MAX);
        end
        return val[VAL_W-1:0];
    endfunction

    // Idle cycles before one transfer on either side.
    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic add_row(input logic fresh, input logic [VAL_W-1:0] item_size,
                           input logic [VAL_W-1:0] item_weight, input logic typed,
                           input logic [7:0] bin_index, input logic opened_new,
                           input logic oversize, input logic bins_full,
                           input logic [8:0] bins_in_use);
        t_row row;
        row.fresh                  = fresh;
        row.item_size              = item_size;
        row.item_weight            = item_weight;
        row.gold.typed             = typed;
        row.gold.want.bin_index    = bin_index;
        row.gold.want.opened_new   = opened_new;
        row.gold.want.oversize     = oversize;
        row.gold.want.bins_full    = bins_full;
        row.gold.want.bins_in_use  = bins_in_use;
        rows.insert(rows.size(), row);
    endtask

    // Sends one item; tvalid stays high when the next gap is zero.
    task automatic send_item(input logic fresh, input logic [VAL_W-1:0] item_size,
                             input logic [VAL_W-1:0] item_weight, input t_golden gold);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        golden_q.insert(golden_q.size(), gold);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - 2 * VAL_W - 1){1'b0}}, item_weight, item_size, fresh};
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
    endtask

    // Writes one limit register and reads it back.
    task automatic write_limit(input logic reg_idx, input logic [VAL_W-1:0] cap);
        logic [APB_DATA_W-1:0] value;
        int unsigned upper;
        upper = $urandom_range(0, 255);
        value = {upper[7:0], cap};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_idx == REG_SIZE_LIMIT) begin
            size_cap = cap;
        end else begin
            weight_cap = cap;
        end
        // Read back; only the low 24 bits are kept by the register.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(APB_DATA_W - VAL_W){1'b0}}, cap}) begin
            $display("%0t: limit read back at %0d expected %0h, got %0h",
                     $time, reg_idx, cap, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (n_results < n_sent) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Predicts each accepted item and checks each transferred result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted = first_fit_place(s_axis_tdata[IN_FRESH_BIT],
                                            s_axis_tdata[IN_SIZE_LSB +: VAL_W],
                                            s_axis_tdata[IN_WEIGHT_LSB +: VAL_W]);
                gold_head = '0;
                if (golden_q.size() != 0) begin
                    gold_head = golden_q.pop_front();
                end
                placement_q.insert(placement_q.size(),
                                   gold_head.typed ? gold_head.want : predicted);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (placement_q.size() == 0) begin
                    $display("%0t: result %0h with no item outstanding", $time, m_axis_tdata);
                    errors++;
                end else begin
                    wanted = placement_q.pop_front();
                    check_field("bin_index", int'(wanted.bin_index),
                                int'(m_axis_tdata[OUT_BIN_LSB +: OUT_BIN_W]));
                    check_field("opened_new", int'(wanted.opened_new),
                                int'(m_axis_tdata[OUT_OPEN_BIT]));
                    check_field("oversize", int'(wanted.oversize),
                                int'(m_axis_tdata[OUT_OVER_BIT]));
                    check_field("bins_full", int'(wanted.bins_full),
                                int'(m_axis_tdata[OUT_FULL_BIT]));
                    check_field("bins_in_use", int'(wanted.bins_in_use),
                                int'(m_axis_tdata[OUT_USED_LSB +: OUT_USED_W]));
                end
            end
        end
    end

    // Receiver: stalls a random number of cycles before each transfer.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Stimulus: directed table, then random phases with their own limits.
    initial begin
        logic [VAL_W-1:0] phase_size_cap;
        logic [VAL_W-1:0] phase_weight_cap;
        logic [VAL_W-1:0] item_size;
        logic [VAL_W-1:0] item_weight;
        logic             fresh;
        t_golden          none;
        int               count;
        int               k;
        int               p;

        errors    = 0;
        n_sent    = 0;
        n_results = 0;
        no_idle   = 1'b0;
        none      = '0;
        bins_open  = '0;
        size_cap   = LIMIT_RESET;
        weight_cap = LIMIT_RESET;
        for (k = 0; k < BIN_COUNT; k++) begin
            size_total[k]   = '0;
            weight_total[k] = '0;
        end

        // Directed items under the reset limits of 1000.
        add_row(1'b0, 24'd0, 24'd0, 1'b1, 8'd0, 1'b1, 1'b0, 1'b0, 9'd1);
        add_row(1'b0, 24'd1000, 24'd0, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0, 9'd1);
        add_row(1'b0, 24'd1, 24'd0, 1'b1, 8'd1, 1'b1, 1'b0, 1'b0, 9'd2);
        add_row(1'b0, 24'd0, 24'd1000, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0, 9'd2);
        add_row(1'b0, VAL_MAX, VAL_MAX, 1'b1, 8'd2, 1'b1, 1'b1, 1'b0, 9'd3);
        add_row(1'b0, 24'd0, 24'd0, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0, 9'd3);
        add_row(1'b1, 24'd5, 24'd5, 1'b1, 8'd0, 1'b1, 1'b0, 1'b0, 9'd1);
        add_row(1'b0, 24'd996, 24'd995, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0);
        add_row(1'b0, 24'd1001, 24'd0, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0);
        add_row(1'b0, 24'd0, 24'd1001, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0);
        add_row(1'b0, 24'd4, 24'd5, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0);
        add_row(1'b1, VAL_MAX, 24'd0, 1'b1, 8'd0, 1'b1, 1'b1, 1'b0, 9'd1);
        add_row(1'b0, 24'd0, VAL_MAX, 1'b1, 8'd1, 1'b1, 1'b1, 1'b0, 9'd2);
        add_row(1'b0, 24'hAAAAAA, 24'h555555, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0);
        add_row(1'b0, 24'h555555, 24'hAAAAAA, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0);
        add_row(1'b1, 24'd1000, 24'd1000, 1'b1, 8'd0, 1'b1, 1'b0, 1'b0, 9'd1);
        add_row(1'b0, 24'd0, 24'd0, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0, 9'd1);
        add_row(1'b0, 24'd1, 24'd1, 1'b1, 8'd1, 1'b1, 1'b0, 1'b0, 9'd2);
        add_row(1'b1, 24'h3FF, 24'd1, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0);

        // Hold reset, then release it.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            send_item(rows[k].fresh, rows[k].item_size, rows[k].item_weight, rows[k].gold);
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Random phases, each under its own pair of limits.
        for (p = 0; p < PHASES; p++) begin
            count = 120;
            no_idle = 1'b0;
            case (p)
                0: begin
                    phase_size_cap   = LIMIT_RESET;
                    phase_weight_cap = LIMIT_RESET;
                end
                FILL_PHASE: begin
                    // Zero limits: nearly every item opens a bin until all are used.
                    phase_size_cap   = '0;
                    phase_weight_cap = '0;
                    count = 360;
                end
                2: begin
                    phase_size_cap   = VAL_MAX;
                    phase_weight_cap = VAL_MAX;
                    no_idle = 1'b1;
                end
                3: begin
                    phase_size_cap   = VAL_W'($urandom_range(1, 4095));
                    phase_weight_cap = VAL_W'($urandom_range(1, 4095));
                end
                4: begin
                    phase_size_cap   = VAL_MAX;
                    phase_weight_cap = '0;
                end
                default: begin
                    phase_size_cap   = VAL_W'($urandom);
                    phase_weight_cap = VAL_W'($urandom);
                end
            endcase
            write_limit(REG_SIZE_LIMIT, phase_size_cap);
            write_limit(REG_WEIGHT_LIMIT, phase_weight_cap);

            for (k = 0; k < count; k++) begin
                item_size   = pick_value(phase_size_cap);
                item_weight = pick_value(phase_weight_cap);
                if (p == FILL_PHASE) begin
                    fresh = (k == 0);
                    if (item_size == 0 && $urandom_range(0, 9) != 0) begin
                        item_size = 24'd1;
                    end
                end else if (k == 0) begin
                    fresh = 1'($urandom_range(0, 1));
                end else begin
                    fresh = ($urandom_range(0, 39) == 0);
                end
                send_item(fresh, item_size, item_weight, none);
            end
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (300) @(posedge i_clk);
        if (placement_q.size() != 0) begin
            $display("%0t: %0d results expected but never seen", $time, placement_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("two_dim_first_fit_bin_packer_unit_test: done, clean");
        end else begin
            $display("two_dim_first_fit_bin_packer_unit_test: done, errors");
        end
        $finish;
    end

    // Run limit, several times the slowest correct run.
    initial begin
        #12_000_000;
        $display("%0t: run limit reached", $time);
        $display("two_dim_first_fit_bin_packer_unit_test: done, errors");
        $finish;
    end

endmodule
